// ===== design/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants for the rotation matrix to quaternion unit
// Field widths, lane and axis numbering, magnitude limit and default format.
// ----------------------------------------------------------------------------
package rmq_pkg;

	// Default count of fraction bits in the fixed-point format (Q1.14)
	localparam int FRAC_BITS_DEF = 14;

	// Fixed widths of the matrix entries and result components
	localparam int ELEM_W = 16;
	localparam int MAG_W  = 15;
	localparam int DIFF_W = ELEM_W + 1;

	// Four quaternion lanes, three signed axes
	localparam int LANES = 4;
	localparam int AXES  = 3;

	localparam int LANE_W = 0;
	localparam int LANE_X = 1;
	localparam int LANE_Y = 2;
	localparam int LANE_Z = 3;

	localparam int AX_X = 0;
	localparam int AX_Y = 1;
	localparam int AX_Z = 2;

	localparam logic [MAG_W-1:0] MAG_MAX = '1;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic        [MAG_W-1:0]  mag_t;
	typedef logic signed [ELEM_W-1:0] comp_t;

endpackage

// ===== design/rmq_mat_if.sv =====
// ----------------------------------------------------------------------------
// rmq_mat_if: matrix input channel
// Valid/ready handshake carrying the nine rotation entries of one pose.
// ----------------------------------------------------------------------------
interface rmq_mat_if;
	import rmq_pkg::*;

	logic  valid;
	logic  ready;
	elem_t m00;
	elem_t m01;
	elem_t m02;
	elem_t m10;
	elem_t m11;
	elem_t m12;
	elem_t m20;
	elem_t m21;
	elem_t m22;

	modport source (
		output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input  ready
	);

	modport sink (
		input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready
	);
endinterface

// ===== design/rmq_quat_if.sv =====
// ----------------------------------------------------------------------------
// rmq_quat_if: quaternion output channel
// Valid/ready handshake carrying one unit quaternion.
// ----------------------------------------------------------------------------
interface rmq_quat_if;
	import rmq_pkg::*;

	logic  valid;
	logic  ready;
	mag_t  quat_w;
	comp_t quat_x;
	comp_t quat_y;
	comp_t quat_z;

	modport source (
		output valid, quat_w, quat_x, quat_y, quat_z,
		input  ready
	);

	modport sink (
		input  valid, quat_w, quat_x, quat_y, quat_z,
		output ready
	);
endinterface

// ===== design/rmq_root_stage.sv =====
// ----------------------------------------------------------------------------
// rmq_root_stage: one digit step of the pipelined square root
// Resolves one root bit in each of the four lanes and registers the result.
// ----------------------------------------------------------------------------
module rmq_root_stage #(
	parameter int ROOT_W = 16,
	parameter int RAD_W  = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [rmq_pkg::LANES-1:0][ROOT_W+1:0] in_rem,
	input  logic [rmq_pkg::LANES-1:0][ROOT_W-1:0] in_root,
	input  logic [rmq_pkg::LANES-1:0][RAD_W-1:0]  in_rad,
	input  logic [rmq_pkg::AXES-1:0]              in_neg,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [rmq_pkg::LANES-1:0][ROOT_W+1:0] out_rem,
	output logic [rmq_pkg::LANES-1:0][ROOT_W-1:0] out_root,
	output logic [rmq_pkg::LANES-1:0][RAD_W-1:0]  out_rad,
	output logic [rmq_pkg::AXES-1:0]              out_neg
);
	import rmq_pkg::*;

	localparam int REM_W = ROOT_W + 2;

	logic                              valid_s2;
	logic [LANES-1:0][REM_W-1:0]       rem_s2;
	logic [LANES-1:0][ROOT_W-1:0]      root_s2;
	logic [LANES-1:0][RAD_W-1:0]       rad_s2;
	logic [AXES-1:0]                   neg_s2;

	logic [LANES-1:0][REM_W-1:0]       rem_sh;
	logic [LANES-1:0][REM_W-1:0]       trial;
	logic [LANES-1:0]                  fits;
	logic [LANES-1:0][REM_W-1:0]       rem_nxt;
	logic [LANES-1:0][ROOT_W-1:0]      root_nxt;
	logic [LANES-1:0][RAD_W-1:0]       rad_nxt;

	// bring down the next radicand bit pair and try the next root bit
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			rem_sh[l]   = {in_rem[l][REM_W-3:0], in_rad[l][RAD_W-1 -: 2]};
			trial[l]    = {in_root[l], 2'b01};
			fits[l]     = rem_sh[l] >= trial[l];
			rem_nxt[l]  = fits[l] ? (rem_sh[l] - trial[l]) : rem_sh[l];
			root_nxt[l] = {in_root[l][ROOT_W-2:0], fits[l]};
			rad_nxt[l]  = in_rad[l] << 2;
		end
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rem_s2  <= rem_nxt;
			root_s2 <= root_nxt;
			rad_s2  <= rad_nxt;
			neg_s2  <= in_neg;
		end
	end

	assign out_valid = valid_s2;
	assign out_rem   = rem_s2;
	assign out_root  = root_s2;
	assign out_rad   = rad_s2;
	assign out_neg   = neg_s2;

endmodule

// ===== design/rotation_matrix_to_quaternion_unit.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit: pose matrix to unit quaternion
// Clamped diagonal sums, pipelined half square roots, signs from off-diagonals.
// ----------------------------------------------------------------------------
// Pipeline: one sum stage, one root stage per root bit, one output stage
//   between an accepted matrix beat and its quaternion beat.
// Throughput: one beat per cycle while quat.ready is high; each stage holds its beat until the next
//   stage frees up, and a bubble anywhere lets the input side keep filling.
// Reset: arst_n clears the valid bit of every stage; data registers keep junk.
module rotation_matrix_to_quaternion_unit #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	rmq_mat_if.sink           mat,
	rmq_quat_if.source        quat
);
	import rmq_pkg::*;

	// Signed sum of one and three diagonal terms
	localparam int HI_W   = (FRAC_BITS > 17) ? FRAC_BITS : 17;
	localparam int SUM_W  = HI_W + 2;
	// Radicand is the positive sum shifted up by the fraction bits, padded even
	localparam int SQ_W   = SUM_W - 1 + FRAC_BITS;
	localparam int RAD_W  = SQ_W + (SQ_W % 2);
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	// Half root before saturation, widened so the limit always fits
	localparam int HALF_W = ROOT_W - 1;
	localparam int EXT_W  = (HALF_W > ELEM_W) ? HALF_W : ELEM_W;

	localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) << FRAC_BITS;
	localparam logic [ELEM_W-1:0] COMP_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

	// ---------------------------------------------------------------- stage 1
	logic signed [SUM_W-1:0]  a_ext, b_ext, c_ext;
	logic signed [SUM_W-1:0]  sum [LANES];
	logic [LANES-1:0][RAD_W-1:0] rad_c;
	logic signed [DIFF_W-1:0] diff [AXES];
	logic [AXES-1:0]          neg_c;

	logic                        valid_s1;
	logic [LANES-1:0][RAD_W-1:0] rad_s1;
	logic [AXES-1:0]             neg_s1;

	// chain of root stages; slot 0 is fed by stage 1
	logic [ROOT_W:0]             ch_valid;
	logic [ROOT_W:0]             ch_ready;
	logic [LANES-1:0][REM_W-1:0]  ch_rem  [ROOT_W+1];
	logic [LANES-1:0][ROOT_W-1:0] ch_root [ROOT_W+1];
	logic [LANES-1:0][RAD_W-1:0]  ch_rad  [ROOT_W+1];
	logic [AXES-1:0]              ch_neg  [ROOT_W+1];

	always_comb begin
		a_ext = SUM_W'(mat.m00);
		b_ext = SUM_W'(mat.m11);
		c_ext = SUM_W'(mat.m22);

		// w: +a+b+c, x: +a-b-c, y: -a+b-c, z: -a-b+c
		sum[LANE_W] = ONE + a_ext + b_ext + c_ext;
		sum[LANE_X] = ONE + a_ext - b_ext - c_ext;
		sum[LANE_Y] = ONE - a_ext + b_ext - c_ext;
		sum[LANE_Z] = ONE - a_ext - b_ext + c_ext;

		// clamp non-positive sums to a zero radicand
		for (int l = 0; l < LANES; l++) begin
			if (!sum[l][SUM_W-1] && (sum[l] != '0)) begin
				rad_c[l] = RAD_W'({sum[l][SUM_W-2:0], {FRAC_BITS{1'b0}}});
			end else begin
				rad_c[l] = '0;
			end
		end

		// sign sources: opposite off-diagonal differences, zero counts positive
		diff[AX_X] = {mat.m21[ELEM_W-1], mat.m21} - {mat.m12[ELEM_W-1], mat.m12};
		diff[AX_Y] = {mat.m02[ELEM_W-1], mat.m02} - {mat.m20[ELEM_W-1], mat.m20};
		diff[AX_Z] = {mat.m10[ELEM_W-1], mat.m10} - {mat.m01[ELEM_W-1], mat.m01};
		for (int k = 0; k < AXES; k++) begin
			neg_c[k] = diff[k][DIFF_W-1];
		end
	end

	assign mat.ready = !valid_s1 || ch_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (mat.ready) begin
			valid_s1 <= mat.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (mat.valid && mat.ready) begin
			rad_s1 <= rad_c;
			neg_s1 <= neg_c;
		end
	end

	// ---------------------------------------------------------------- stage 2
	// start every lane with an empty remainder and root
	assign ch_valid[0] = valid_s1;
	assign ch_rem[0]   = '0;
	assign ch_root[0]  = '0;
	assign ch_rad[0]   = rad_s1;
	assign ch_neg[0]   = neg_s1;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_root
		rmq_root_stage #(
			.ROOT_W (ROOT_W),
			.RAD_W  (RAD_W)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (ch_valid[i]),
			.in_ready  (ch_ready[i]),
			.in_rem    (ch_rem[i]),
			.in_root   (ch_root[i]),
			.in_rad    (ch_rad[i]),
			.in_neg    (ch_neg[i]),
			.out_valid (ch_valid[i+1]),
			.out_ready (ch_ready[i+1]),
			.out_rem   (ch_rem[i+1]),
			.out_root  (ch_root[i+1]),
			.out_rad   (ch_rad[i+1]),
			.out_neg   (ch_neg[i+1])
		);
	end

	// ---------------------------------------------------------------- stage 3
	logic [EXT_W-1:0]  half_ext [LANES];
	mag_t              mag [LANES];
	logic [ELEM_W-1:0] pos [AXES];
	comp_t             comp [AXES];

	logic      valid_s3;
	mag_t      quat_w_s3;
	comp_t     comp_s3 [AXES];

	// halve the root, saturate, then apply the axis sign
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			half_ext[l] = EXT_W'(ch_root[ROOT_W][l][ROOT_W-1:1]);
			if (half_ext[l] > EXT_W'(MAG_MAX)) begin
				mag[l] = MAG_MAX;
			end else begin
				mag[l] = half_ext[l][MAG_W-1:0];
			end
		end
		for (int k = 0; k < AXES; k++) begin
			pos[k] = {1'b0, mag[k+1]};
			if (ch_neg[ROOT_W][k]) begin
				comp[k] = ELEM_W'('0 - pos[k]);
			end else begin
				comp[k] = pos[k];
			end
		end
	end

	assign ch_ready[ROOT_W] = !valid_s3 || quat.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ch_ready[ROOT_W]) begin
			valid_s3 <= ch_valid[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (ch_valid[ROOT_W] && ch_ready[ROOT_W]) begin
			quat_w_s3 <= mag[LANE_W];
			comp_s3   <= comp;
		end
	end

	assign quat.valid  = valid_s3;
	assign quat.quat_w = quat_w_s3;
	assign quat.quat_x = comp_s3[AX_X];
	assign quat.quat_y = comp_s3[AX_Y];
	assign quat.quat_z = comp_s3[AX_Z];

`ifndef SYNTHESIS
	// the root recurrence leaves a remainder no larger than twice the root
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ch_valid[ROOT_W] |->
			(ch_rem[ROOT_W][LANE_W] <= {1'b0, ch_root[ROOT_W][LANE_W], 1'b0}) &&
			(ch_rem[ROOT_W][LANE_X] <= {1'b0, ch_root[ROOT_W][LANE_X], 1'b0}) &&
			(ch_rem[ROOT_W][LANE_Y] <= {1'b0, ch_root[ROOT_W][LANE_Y], 1'b0}) &&
			(ch_rem[ROOT_W][LANE_Z] <= {1'b0, ch_root[ROOT_W][LANE_Z], 1'b0}))
		else $error("root remainder out of bound");

	// saturation before negation keeps every signed component off the minimum
	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid |-> (quat.quat_x != COMP_MIN) && (quat.quat_y != COMP_MIN) &&
			(quat.quat_z != COMP_MIN))
		else $error("signed component reached the minimum code");

	// a blocked last root stage keeps its beat intact
	a_tail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ch_valid[ROOT_W] && !ch_ready[ROOT_W]) |=>
			(ch_valid[ROOT_W] && $stable(ch_root[ROOT_W]) && $stable(ch_neg[ROOT_W])))
		else $error("last root stage lost its beat under stall");
`endif

endmodule
